>>> rtl/core/hilbert_index_to_row_col_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Hilbert index mapper
// Immediate-style wrappers around concurrent properties; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef HILBERT_INDEX_TO_ROW_COL_ASSERT_SVH
`define HILBERT_INDEX_TO_ROW_COL_ASSERT_SVH

`ifndef SYNTHESIS
`define HIRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HIRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HIRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HIRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/hirc_pkg.sv
// ----------------------------------------------------------------------------
// hirc_pkg
// Shared constants for the Hilbert index to row/column mapper.
// ----------------------------------------------------------------------------
package hirc_pkg;

  localparam int MAX_LEVELS_DEF = 32;

  localparam int IDX_W   = 64;
  localparam int COORD_W = 32;
  localparam int LEVEL_W = 6;
  localparam int ROT_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_LEVEL    = 3'd0,
    CFG_STOP_LEVEL     = 3'd1,
    CFG_HILBERT_MODE   = 3'd2,
    CFG_INITIAL_ROTATE = 3'd3,
    CFG_INITIAL_FLIP   = 3'd4
  } cfg_reg_t;

  localparam logic [LEVEL_W-1:0] START_LEVEL_RST    = 6'd31;
  localparam logic [LEVEL_W-1:0] STOP_LEVEL_RST     = 6'd0;
  localparam logic               HILBERT_MODE_RST   = 1'b1;
  localparam logic [ROT_W-1:0]   INITIAL_ROTATE_RST = 2'd0;
  localparam logic               INITIAL_FLIP_RST   = 1'b0;

endpackage

>>> rtl/core/hilbert_index_to_row_col.sv
// ----------------------------------------------------------------------------
// hilbert_index_to_row_col
// An accepted word passes through the input register and then the result
// register before out_valid. Throughput: one word per cycle; busy is always low.
// Rotate/flip state per level is a suffix parity over the quadrant digits,
// done as a log-depth prefix tree between the input and result registers.
// Synchronous active-low reset clears valids and loads register defaults.
// Results are not held: the receiver takes each one in its strobe cycle.
// ----------------------------------------------------------------------------
`include "hilbert_index_to_row_col_assert.svh"

module hilbert_index_to_row_col #(
  parameter int MAX_LEVELS = hirc_pkg::MAX_LEVELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config write port
  input  logic                             cfg_we,
  input  logic [hirc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hirc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input words
  input  logic                             start,
  output logic                             busy,
  input  logic [hirc_pkg::IDX_W-1:0]       in_point_index,
  // result words
  output logic                             out_valid,
  output logic [hirc_pkg::COORD_W-1:0]     out_row,
  output logic [hirc_pkg::COORD_W-1:0]     out_col
);

  localparam int STAGES = $clog2(MAX_LEVELS);

  // configuration registers
  logic [hirc_pkg::LEVEL_W-1:0] start_level_r;
  logic [hirc_pkg::LEVEL_W-1:0] stop_level_r;
  logic                         hilbert_mode_r;
  logic [hirc_pkg::ROT_W-1:0]   initial_rotate_r;
  logic                         initial_flip_r;

  // input stage
  logic                         s1_valid_r;
  logic [hirc_pkg::IDX_W-1:0]   point_index_r;

  // result stage
  logic                         out_valid_r;
  logic [hirc_pkg::COORD_W-1:0] row_r, row_nxt;
  logic [hirc_pkg::COORD_W-1:0] col_r, col_nxt;

  logic [hirc_pkg::LEVEL_W-1:0] levels;
  logic [MAX_LEVELS-1:0]        act;
  logic [MAX_LEVELS-1:0]        tog3;
  logic [MAX_LEVELS-1:0]        tog03;
  logic [MAX_LEVELS-1:0]        px3  [STAGES+1];
  logic [MAX_LEVELS-1:0]        px03 [STAGES+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_level_r    <= hirc_pkg::START_LEVEL_RST;
      stop_level_r     <= hirc_pkg::STOP_LEVEL_RST;
      hilbert_mode_r   <= hirc_pkg::HILBERT_MODE_RST;
      initial_rotate_r <= hirc_pkg::INITIAL_ROTATE_RST;
      initial_flip_r   <= hirc_pkg::INITIAL_FLIP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hirc_pkg::CFG_START_LEVEL:    start_level_r    <= cfg_data;
        hirc_pkg::CFG_STOP_LEVEL:     stop_level_r     <= cfg_data;
        hirc_pkg::CFG_HILBERT_MODE:   hilbert_mode_r   <= cfg_data[0];
        hirc_pkg::CFG_INITIAL_ROTATE: initial_rotate_r <= cfg_data[hirc_pkg::ROT_W-1:0];
        hirc_pkg::CFG_INITIAL_FLIP:   initial_flip_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= start && !busy;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      point_index_r <= in_point_index;
    end
    if (s1_valid_r) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  assign levels = (start_level_r > hirc_pkg::LEVEL_W'(MAX_LEVELS)) ?
                  hirc_pkg::LEVEL_W'(MAX_LEVELS) : start_level_r;

  // per-level toggle flags; only levels that are walked count
  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++) begin
      act[i]   = (hirc_pkg::LEVEL_W'(i) < levels);
      tog3[i]  = act[i] && (point_index_r[2*i +: 2] == 2'd3);
      tog03[i] = act[i] && ((point_index_r[2*i +: 2] == 2'd3) ||
                            (point_index_r[2*i +: 2] == 2'd0));
    end
  end

  // inclusive suffix parity: px[STAGES][i] = xor of tog[j] for j >= i
  always_comb begin
    px3[0]  = tog3;
    px03[0] = tog03;
    for (int s = 0; s < STAGES; s++) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        if (i + (1 << s) < MAX_LEVELS) begin
          px3[s+1][i]  = px3[s][i]  ^ px3[s][i + (1 << s)];
          px03[s+1][i] = px03[s][i] ^ px03[s][i + (1 << s)];
        end else begin
          px3[s+1][i]  = px3[s][i];
          px03[s+1][i] = px03[s][i];
        end
      end
    end
  end

  always_comb begin
    logic [1:0]                   q;
    logic [1:0]                   k;
    logic [1:0]                   rot;
    logic                         flp;
    logic                         zord;
    logic [hirc_pkg::LEVEL_W:0]   bias;
    row_nxt = '0;
    col_nxt = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      q = point_index_r[2*i +: 2];
      // state entering this level comes from the levels above it
      if (i + 1 < MAX_LEVELS) begin
        rot = {initial_rotate_r[1] ^ px3[STAGES][i+1], initial_rotate_r[0]};
        flp = initial_flip_r ^ px03[STAGES][i+1];
      end else begin
        rot = initial_rotate_r;
        flp = initial_flip_r;
      end
      bias = {1'b0, stop_level_r} + (hirc_pkg::LEVEL_W+1)'(i + 1);
      zord = !hilbert_mode_r || (bias <= (hirc_pkg::LEVEL_W+1)'(2));
      if (zord) begin
        case (q)
          2'd0:    k = 2'd0;
          2'd1:    k = 2'd3;
          2'd2:    k = 2'd1;
          default: k = 2'd2;
        endcase
      end else begin
        k = q - rot;
        if (flp && k[0]) begin
          k[1] = ~k[1];
        end
      end
      row_nxt[i] = act[i] && ((k == 2'd1) || (k == 2'd2));
      col_nxt[i] = act[i] && ((k == 2'd2) || (k == 2'd3));
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = row_r;
  assign out_col   = col_r;

  `HIRC_ASSERT_IMPL(a_latency, clk, rst_n, start, ##2 out_valid)
  `HIRC_ASSERT_NEXT(a_s1_to_out, clk, rst_n, s1_valid_r, out_valid_r)
  `HIRC_ASSERT_IMPL(a_no_spurious, clk, rst_n, out_valid, $past(start, 2))
  `HIRC_ASSERT_IMPL(a_zero_levels, clk, rst_n, out_valid && (start_level_r == '0),
                    (out_row == '0) && (out_col == '0))

endmodule

>>> tb/sv/hilbert_index_to_row_col_tb.sv
// ----------------------------------------------------------------------------
// Testbench for hilbert_index_to_row_col
// Drives point indexes through the command port under a series of register
// settings (defaults, extremes and random) and checks every row/col word
// against a behavioral predictor of the curve walk, in order of arrival.
// ----------------------------------------------------------------------------
module hilbert_index_to_row_col_tb;

  localparam int STALL_LIMIT   = 2000;
  localparam int N_PHASES      = 24;
  localparam int N_FIXED       = 11;
  localparam int WORDS_PER_SET = 70;

  // visiting slot k -> row/col offset bit; Z-order quadrant -> slot
  localparam logic [3:0] SLOT_ROW = 4'b0110;
  localparam logic [3:0] SLOT_COL = 4'b1100;
  localparam logic [1:0] ZORDER_SLOT [4] = '{2'd0, 2'd3, 2'd1, 2'd2};

  // fixed settings: start, stop, hilbert, rotate, flip
  localparam int FIX_START [N_FIXED] = '{32, 63, 33, 0, 1, 2, 3, 5, 16, 32, 8};
  localparam int FIX_STOP  [N_FIXED] = '{0, 0, 1, 5, 0, 0, 1, 63, 2, 63, 0};
  localparam int FIX_MODE  [N_FIXED] = '{1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 1};
  localparam int FIX_ROT   [N_FIXED] = '{0, 3, 1, 2, 0, 1, 2, 3, 0, 3, 0};
  localparam int FIX_FLIP  [N_FIXED] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 1};

  typedef struct packed {
    logic [hirc_pkg::IDX_W-1:0]   idx;
    logic [hirc_pkg::COORD_W-1:0] row;
    logic [hirc_pkg::COORD_W-1:0] col;
  } coord_word_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [hirc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hirc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            start;
  logic                            busy;
  logic [hirc_pkg::IDX_W-1:0]      in_point_index;
  logic                            out_valid;
  logic [hirc_pkg::COORD_W-1:0]    out_row;
  logic [hirc_pkg::COORD_W-1:0]    out_col;

  // predictor copy of the registers
  logic [hirc_pkg::LEVEL_W-1:0] start_lvl_cfg;
  logic [hirc_pkg::LEVEL_W-1:0] stop_lvl_cfg;
  logic                         hilbert_cfg;
  logic [hirc_pkg::ROT_W-1:0]   rotate_cfg;
  logic                         flip_cfg;

  logic [hirc_pkg::IDX_W-1:0] point_q [$];
  coord_word_t                coord_q [$];
  int                         idle_pct;
  int                         sent_words;
  int                         checked_words;
  int                         err_count;
  int                         settings_done;
  int                         stall_cycles;

  hilbert_index_to_row_col dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .in_point_index (in_point_index),
    .out_valid      (out_valid),
    .out_row        (out_row),
    .out_col        (out_col)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // walk the levels from the top, carrying rotate/flip down
  function automatic coord_word_t map_point(input logic [hirc_pkg::IDX_W-1:0] idx);
    coord_word_t                res;
    int                         levels;
    int                         lvl;
    logic [hirc_pkg::ROT_W-1:0] rot;
    logic                       flp;
    logic [1:0]                 q;
    logic [1:0]                 k;
    res.idx = idx;
    res.row = '0;
    res.col = '0;
    levels = (int'(start_lvl_cfg) > hirc_pkg::MAX_LEVELS_DEF) ? hirc_pkg::MAX_LEVELS_DEF :
             int'(start_lvl_cfg);
    rot = rotate_cfg;
    flp = flip_cfg;
    for (lvl = levels; lvl >= 1; lvl--) begin
      q = idx[2*lvl-2 +: 2];
      if (hilbert_cfg && (lvl + int'(stop_lvl_cfg)) > 2) begin
        k = q - rot;
        if (flp && k[0]) k ^= 2'b10;
      end else begin
        k = ZORDER_SLOT[q];
      end
      // offsets per level land on disjoint bits, so set instead of add
      if (SLOT_ROW[k]) res.row[lvl-1] = 1'b1;
      if (SLOT_COL[k]) res.col[lvl-1] = 1'b1;
      if (q == 2'd3) rot ^= 2'b10;
      if (q == 2'd0 || q == 2'd3) flp = ~flp;
    end
    return res;
  endfunction

  function automatic logic [hirc_pkg::IDX_W-1:0] pick_index();
    logic [hirc_pkg::IDX_W-1:0] v;
    logic [1:0]                 d0;
    logic [1:0]                 d1;
    int                         kind;
    int                         i;
    v = {$urandom, $urandom};
    kind = $urandom_range(9);
    if (kind < 3) begin
      // two-symbol digit strings stress the rotate/flip chain
      d0 = 2'($urandom);
      d1 = 2'($urandom);
      for (i = 0; i < 32; i++) v[2*i +: 2] = v[2*i] ? d1 : d0;
    end else if (kind == 3) begin
      v = v >> $urandom_range(63);
    end else if (kind == 4) begin
      v = v | ({hirc_pkg::IDX_W{1'b1}} << $urandom_range(63));
    end
    return v;
  endfunction

  function automatic void queue_point(input logic [hirc_pkg::IDX_W-1:0] v);
    point_q.insert(point_q.size(), v);
  endfunction

  // driver: issues one word per cycle unless idling or held by busy
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        coord_q.insert(coord_q.size(), map_point(in_point_index));
        sent_words++;
      end
      if (start && busy) begin
        // hold the word until taken
      end else if (point_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start          <= 1'b1;
        in_point_index <= point_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results cannot be held off, check each in its strobe cycle
  always @(posedge clk) begin
    coord_word_t exp_w;
    if (rst_n && out_valid === 1'b1) begin
      if (coord_q.size() == 0) begin
        $display("%0t: unexpected word row=%h col=%h", $time, out_row, out_col);
        err_count++;
      end else begin
        exp_w = coord_q.pop_front();
        checked_words++;
        if (out_row !== exp_w.row) begin
          $display("%0t: idx=%h row expected %h actual %h", $time, exp_w.idx, exp_w.row,
                   out_row);
          err_count++;
        end
        if (out_col !== exp_w.col) begin
          $display("%0t: idx=%h col expected %h actual %h", $time, exp_w.idx, exp_w.col,
                   out_col);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic cfg_write(input hirc_pkg::cfg_reg_t sel, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value[hirc_pkg::CFG_DATA_W-1:0];
    case (sel)
      hirc_pkg::CFG_START_LEVEL:    start_lvl_cfg = value[hirc_pkg::LEVEL_W-1:0];
      hirc_pkg::CFG_STOP_LEVEL:     stop_lvl_cfg  = value[hirc_pkg::LEVEL_W-1:0];
      hirc_pkg::CFG_HILBERT_MODE:   hilbert_cfg   = value[0];
      hirc_pkg::CFG_INITIAL_ROTATE: rotate_cfg    = value[hirc_pkg::ROT_W-1:0];
      hirc_pkg::CFG_INITIAL_FLIP:   flip_cfg      = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int lvl0, input int lvl1, input int mode, input int rot,
                               input int flp);
    cfg_write(hirc_pkg::CFG_START_LEVEL, lvl0);
    cfg_write(hirc_pkg::CFG_STOP_LEVEL, lvl1);
    cfg_write(hirc_pkg::CFG_HILBERT_MODE, mode);
    cfg_write(hirc_pkg::CFG_INITIAL_ROTATE, rot);
    cfg_write(hirc_pkg::CFG_INITIAL_FLIP, flp);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // sender pause: wait until every issued word has come back
  task automatic wait_drained();
    do @(negedge clk); while (point_q.size() != 0 || start || coord_q.size() != 0);
  endtask

  initial begin
    int p;
    int i;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = hirc_pkg::CFG_START_LEVEL;
    cfg_data       = '0;
    start          = 1'b0;
    in_point_index = '0;
    start_lvl_cfg  = hirc_pkg::START_LEVEL_RST;
    stop_lvl_cfg   = hirc_pkg::STOP_LEVEL_RST;
    hilbert_cfg    = hirc_pkg::HILBERT_MODE_RST;
    rotate_cfg     = hirc_pkg::INITIAL_ROTATE_RST;
    flip_cfg       = hirc_pkg::INITIAL_FLIP_RST;
    idle_pct       = 14;
    sent_words     = 0;
    checked_words  = 0;
    err_count      = 0;
    settings_done  = 0;
    stall_cycles   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words under reset defaults (31 levels, top two bits ignored)
    queue_point(64'h0);
    queue_point({hirc_pkg::IDX_W{1'b1}});
    queue_point(64'h5555_5555_5555_5555);
    queue_point(64'hAAAA_AAAA_AAAA_AAAA);
    queue_point(64'h3333_3333_3333_3333);
    queue_point(64'hCCCC_CCCC_CCCC_CCCC);
    queue_point(64'h3FFF_FFFF_FFFF_FFFF);
    queue_point(64'hC000_0000_0000_0000);
    queue_point(64'h1);
    queue_point(64'h2);
    queue_point(64'h3);
    queue_point(64'h1000_0000_0000_0000);
    queue_point(64'h2000_0000_0000_0000);
    queue_point(64'h3000_0000_0000_0000);
    queue_point(64'h0123_4567_89AB_CDEF);
    queue_point(64'hFEDC_BA98_7654_3210);
    wait_drained();

    for (p = 0; p < N_PHASES; p++) begin
      if (p == 8) idle_pct = 55;
      if (p == 16) idle_pct = 0;
      if (p < N_FIXED) begin
        apply_setting(FIX_START[p], FIX_STOP[p], FIX_MODE[p], FIX_ROT[p], FIX_FLIP[p]);
      end else begin
        apply_setting($urandom_range(1) ? $urandom_range(63) : $urandom_range(1, 8),
                      $urandom_range(3) != 0 ? $urandom_range(3) : $urandom_range(63),
                      $urandom_range(3) != 0, $urandom_range(3), $urandom_range(1));
      end
      @(negedge clk);
      queue_point(64'h0);
      queue_point({hirc_pkg::IDX_W{1'b1}});
      queue_point(64'h5555_5555_5555_5555);
      queue_point(64'hAAAA_AAAA_AAAA_AAAA);
      for (i = 4; i < WORDS_PER_SET; i++) queue_point(pick_index());
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d of %0d words over %0d register settings plus defaults,", checked_words,
             sent_words, settings_done);
    $display("with sender idle rates of 14, 55 and 0 percent.");
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
